@@ rtl/core/pbbe_pkg.sv @@
package pbbe_pkg;

    // Configuration port geometry.
    localparam int CFG_IDX_BITS  = 4;
    localparam int CFG_DATA_BITS = 48;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_BITS-1:0] REG_START_X      = 4'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_START_Y      = 4'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_END_X        = 4'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_END_Y        = 4'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_BYTES_PER_LN = 4'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_PIXEL_FORMAT = 4'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_PALETTE_LOW  = 4'd6;
    localparam logic [CFG_IDX_BITS-1:0] REG_PALETTE_HIGH = 4'd7;

    // Fixed field widths.
    localparam int BPL_BITS       = 16;
    localparam int FMT_BITS       = 5;
    localparam int PAL_ENTRY_BITS = 24;
    localparam int BIT_POS_BITS   = 3;

    // Pixel format bit positions.
    localparam int FMT_TWO_BIT = 0;
    localparam int FMT_TRANS   = 1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // latch a new word and start unpacking it
        logic skip_byte;  // word of a finished row: only advance the row counters
        logic step;       // handle one pixel position
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic frame_finished;
        logic row_drawn;
        logic emit;       // current pixel position produces a write
        logic slot_free;  // output register can take a write this cycle
        logic last_step;  // current pixel position ends the word
    } t_stat;

endpackage

@@ rtl/core/packed_bitmap_blit_expander.sv @@
// Expands a rectangle's packed 1-bit or 2-bit bitmap, one input word per byte in
// memory order, into pixel writes of column, row and 24-bit palette color,
// least-significant pixel first; last_of_byte marks the final write a byte causes.
// A byte that draws pixels is accepted and then stepped through at one pixel
// position per cycle (up to 8 in 1-bit mode, 4 in 2-bit mode, fewer at a row
// offset or at end_x), by the single pixel step of the datapath; a visible
// pixel waits while the output register is still held by the receiver. Bytes
// that draw nothing (padding, frame finished) need no pixel step. The next byte is
// accepted while the final write of the previous one still waits in the output
// register. Configuration writes are taken every cycle; each write to a defined
// register restarts the frame, and no byte is accepted in the reload cycle after it.
module packed_bitmap_blit_expander
    import pbbe_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int COLOR_BITS = 24
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [7:0]               i_data_byte,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [COORD_BITS-1:0]    o_pixel_x,
    output logic [COORD_BITS-1:0]    o_pixel_y,
    output logic [COLOR_BITS-1:0]    o_pixel_color,
    output logic                     o_last_of_byte
);

    logic [COORD_BITS-1:0]    start_x;
    logic [COORD_BITS-1:0]    start_y;
    logic [COORD_BITS-1:0]    end_x;
    logic [COORD_BITS-1:0]    end_y;
    logic [BPL_BITS-1:0]      bytes_per_line;
    logic [FMT_BITS-1:0]      pixel_format;
    logic [CFG_DATA_BITS-1:0] palette_low;
    logic [CFG_DATA_BITS-1:0] palette_high;
    logic                     restart;
    t_cmd                     cmd;
    t_stat                    stat;

    assign o_cfg_ready = 1'b1;

    // Configuration registers.
    pbbe_cfg #(
        .COORD_BITS (COORD_BITS)
    ) u_cfg (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_start_x        (start_x),
        .o_start_y        (start_y),
        .o_end_x          (end_x),
        .o_end_y          (end_y),
        .o_bytes_per_line (bytes_per_line),
        .o_pixel_format   (pixel_format),
        .o_palette_low    (palette_low),
        .o_palette_high   (palette_high),
        .o_restart        (restart)
    );

    // Sequencer.
    pbbe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_restart  (restart),
        .i_stat     (stat),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    // Unpacking, palette lookup and output register.
    pbbe_dp #(
        .COORD_BITS (COORD_BITS),
        .COLOR_BITS (COLOR_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_restart        (restart),
        .i_data_byte      (i_data_byte),
        .i_start_x        (start_x),
        .i_start_y        (start_y),
        .i_end_x          (end_x),
        .i_end_y          (end_y),
        .i_bytes_per_line (bytes_per_line),
        .i_pixel_format   (pixel_format),
        .i_palette_low    (palette_low),
        .i_palette_high   (palette_high),
        .i_out_ready      (i_out_ready),
        .o_stat           (stat),
        .o_out_valid      (o_out_valid),
        .o_pixel_x        (o_pixel_x),
        .o_pixel_y        (o_pixel_y),
        .o_pixel_color    (o_pixel_color),
        .o_last_of_byte   (o_last_of_byte)
    );

    // No new word is taken while a pixel step is in progress.
    a_no_accept_while_stepping: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        cmd.step |-> !o_in_ready
    ) else $error("word accepted during a pixel step");

    // A visible pixel step always leaves a write in the output register.
    a_emit_fills_output: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (cmd.step && stat.emit) |=> o_out_valid
    ) else $error("visible pixel produced no write");

    // A visible pixel step never overwrites a write that was not taken.
    a_no_overwrite: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (cmd.step && stat.emit) |-> (!o_out_valid || i_out_ready)
    ) else $error("pending write overwritten");

    // The frame reload after a register write holds off new words.
    a_reload_blocks_input: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && o_cfg_ready && (i_cfg_index == REG_START_X)) |=> !o_in_ready
    ) else $error("word accepted during frame reload");

endmodule

@@ rtl/core/pbbe_cfg.sv @@
module pbbe_cfg
    import pbbe_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_valid,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    output logic [COORD_BITS-1:0]    o_start_x,
    output logic [COORD_BITS-1:0]    o_start_y,
    output logic [COORD_BITS-1:0]    o_end_x,
    output logic [COORD_BITS-1:0]    o_end_y,
    output logic [BPL_BITS-1:0]      o_bytes_per_line,
    output logic [FMT_BITS-1:0]      o_pixel_format,
    output logic [CFG_DATA_BITS-1:0] o_palette_low,
    output logic [CFG_DATA_BITS-1:0] o_palette_high,
    output logic                     o_restart
);

    logic [COORD_BITS-1:0]    r_start_x;
    logic [COORD_BITS-1:0]    r_start_y;
    logic [COORD_BITS-1:0]    r_end_x;
    logic [COORD_BITS-1:0]    r_end_y;
    logic [BPL_BITS-1:0]      r_bytes_per_line;
    logic [FMT_BITS-1:0]      r_pixel_format;
    logic [CFG_DATA_BITS-1:0] r_palette_low;
    logic [CFG_DATA_BITS-1:0] r_palette_high;
    logic                     r_restart;
    logic                     known_reg;

    // Any write to a defined register restarts the frame in the cycle after the write,
    // once the new value is in place.
    assign known_reg = (i_cfg_index == REG_START_X) || (i_cfg_index == REG_START_Y)
                    || (i_cfg_index == REG_END_X) || (i_cfg_index == REG_END_Y)
                    || (i_cfg_index == REG_BYTES_PER_LN)
                    || (i_cfg_index == REG_PIXEL_FORMAT)
                    || (i_cfg_index == REG_PALETTE_LOW)
                    || (i_cfg_index == REG_PALETTE_HIGH);

    // Register file.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_x        <= '0;
            r_start_y        <= '0;
            r_end_x          <= '0;
            r_end_y          <= '0;
            r_bytes_per_line <= BPL_BITS'(1);
            r_pixel_format   <= '0;
            r_palette_low    <= '0;
            r_palette_high   <= '0;
            r_restart        <= 1'b0;
        end else begin
            r_restart <= i_cfg_valid && known_reg;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_START_X:      r_start_x        <= i_cfg_data[COORD_BITS-1:0];
                    REG_START_Y:      r_start_y        <= i_cfg_data[COORD_BITS-1:0];
                    REG_END_X:        r_end_x          <= i_cfg_data[COORD_BITS-1:0];
                    REG_END_Y:        r_end_y          <= i_cfg_data[COORD_BITS-1:0];
                    REG_BYTES_PER_LN: r_bytes_per_line <= i_cfg_data[BPL_BITS-1:0];
                    REG_PIXEL_FORMAT: r_pixel_format   <= i_cfg_data[FMT_BITS-1:0];
                    REG_PALETTE_LOW:  r_palette_low    <= i_cfg_data;
                    REG_PALETTE_HIGH: r_palette_high   <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_start_x        = r_start_x;
    assign o_start_y        = r_start_y;
    assign o_end_x          = r_end_x;
    assign o_end_y          = r_end_y;
    assign o_bytes_per_line = r_bytes_per_line;
    assign o_pixel_format   = r_pixel_format;
    assign o_palette_low    = r_palette_low;
    assign o_palette_high   = r_palette_high;
    assign o_restart        = r_restart;

endmodule

@@ rtl/core/pbbe_ctrl.sv @@
module pbbe_ctrl
    import pbbe_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_restart,
    input  t_stat i_stat,
    output logic  o_in_ready,
    output t_cmd  o_cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic r_state;
    logic n_state;
    logic accept;
    logic stall;

    // A word is taken only between words and never while the frame reloads.
    assign o_in_ready = (r_state == ST_IDLE) && !i_restart;
    assign accept     = o_in_ready && i_in_valid;

    // A visible pixel waits while the output register is still occupied.
    assign stall = i_stat.emit && !i_stat.slot_free;

    always_comb begin
        n_state         = r_state;
        o_cmd           = '0;
        case (r_state)
            ST_IDLE: begin
                if (accept && !i_stat.frame_finished) begin
                    if (i_stat.row_drawn) begin
                        o_cmd.skip_byte = 1'b1;
                    end else begin
                        o_cmd.load = 1'b1;
                        n_state    = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                if (!stall) begin
                    o_cmd.step = 1'b1;
                    if (i_stat.last_step) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ rtl/core/pbbe_dp.sv @@
module pbbe_dp
    import pbbe_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int COLOR_BITS = 24
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    input  logic                     i_restart,
    input  logic [7:0]               i_data_byte,
    input  logic [COORD_BITS-1:0]    i_start_x,
    input  logic [COORD_BITS-1:0]    i_start_y,
    input  logic [COORD_BITS-1:0]    i_end_x,
    input  logic [COORD_BITS-1:0]    i_end_y,
    input  logic [BPL_BITS-1:0]      i_bytes_per_line,
    input  logic [FMT_BITS-1:0]      i_pixel_format,
    input  logic [CFG_DATA_BITS-1:0] i_palette_low,
    input  logic [CFG_DATA_BITS-1:0] i_palette_high,
    input  logic                     i_out_ready,
    output t_stat                    o_stat,
    output logic                     o_out_valid,
    output logic [COORD_BITS-1:0]    o_pixel_x,
    output logic [COORD_BITS-1:0]    o_pixel_y,
    output logic [COLOR_BITS-1:0]    o_pixel_color,
    output logic                     o_last_of_byte
);

    // Walk state.
    logic [7:0]              r_byte;
    logic [BIT_POS_BITS-1:0] r_bit;
    logic [COORD_BITS-1:0]   r_column;
    logic [COORD_BITS-1:0]   r_row;
    logic [BPL_BITS-1:0]     r_byte_in_row;
    logic                    r_frame_finished;
    logic                    r_row_drawn;

    // Output register.
    logic                    r_out_valid;
    logic [COORD_BITS-1:0]   r_pixel_x;
    logic [COORD_BITS-1:0]   r_pixel_y;
    logic [COLOR_BITS-1:0]   r_pixel_color;
    logic                    r_last;

    logic                    two_bit;
    logic                    trans;
    logic [BIT_POS_BITS-1:0] offset;
    logic [BIT_POS_BITS-1:0] start_bit;
    logic [7:0]              shifted;
    logic [1:0]              cur_idx;
    logic                    cur_emit;
    logic [3:0]              next_bit;
    logic                    col_end;
    logic                    last_step;
    logic [COORD_BITS-1:0]   remaining;
    logic [7:0]              later_emit;
    logic                    last_pixel;
    logic [CFG_DATA_BITS-1:0] pal_word;
    logic [PAL_ENTRY_BITS-1:0] pal_entry;
    logic                    slot_free;
    logic                    finish_byte;
    logic [BPL_BITS-1:0]     bir_inc;
    logic [BPL_BITS-1:0]     bpl_eff;
    logic                    row_done;

    // Format decode; two-bit mode keeps the offset even.
    assign two_bit   = i_pixel_format[FMT_TWO_BIT];
    assign trans     = i_pixel_format[FMT_TRANS];
    assign offset    = two_bit ? {i_pixel_format[4:3], 1'b0} : i_pixel_format[4:2];
    assign start_bit = (r_byte_in_row == '0) ? offset : '0;

    // Current pixel index and whether it becomes a write.
    assign shifted  = r_byte >> r_bit;
    assign cur_idx  = two_bit ? shifted[1:0] : {1'b0, shifted[0]};
    assign cur_emit = !trans || (cur_idx != 2'd0);

    // Word and row end conditions for the current position.
    assign next_bit  = {1'b0, r_bit} + (two_bit ? 4'd2 : 4'd1);
    assign col_end   = (r_column == i_end_x);
    assign last_step = col_end || next_bit[3];

    // Look ahead: does a later position of this word still produce a write?
    assign remaining = i_end_x - r_column;

    always_comb begin
        logic [8:0] byte9;
        logic [3:0] dq;
        logic [3:0] k;
        logic [1:0] q_idx;
        byte9      = {1'b0, r_byte};
        later_emit = '0;
        for (int q = 0; q < 8; q++) begin
            dq    = 4'(q) - {1'b0, r_bit};
            k     = two_bit ? (dq >> 1) : dq;
            q_idx = two_bit ? {byte9[q+1], byte9[q]} : {1'b0, byte9[q]};
            later_emit[q] = (4'(q) > {1'b0, r_bit})
                         && (!two_bit || !dq[0])
                         && (remaining >= COORD_BITS'(k))
                         && (!trans || (q_idx != 2'd0));
        end
    end

    assign last_pixel = col_end || (later_emit == '0);

    // Palette lookup: bit 1 picks the word, bit 0 the half.
    assign pal_word  = cur_idx[1] ? i_palette_high : i_palette_low;
    assign pal_entry = cur_idx[0] ? pal_word[CFG_DATA_BITS-1:PAL_ENTRY_BITS]
                                  : pal_word[PAL_ENTRY_BITS-1:0];

    assign slot_free = !r_out_valid || i_out_ready;

    // End-of-word bookkeeping for the row counters.
    assign finish_byte = i_cmd.skip_byte || (i_cmd.step && last_step);
    assign bir_inc     = r_byte_in_row + BPL_BITS'(1);
    assign bpl_eff     = (i_bytes_per_line == '0) ? BPL_BITS'(1) : i_bytes_per_line;
    assign row_done    = (bir_inc >= bpl_eff);

    // Walk state update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column         <= '0;
            r_row            <= '0;
            r_byte_in_row    <= '0;
            r_frame_finished <= 1'b0;
            r_row_drawn      <= 1'b0;
            r_bit            <= '0;
        end else if (i_restart) begin
            r_column         <= i_start_x;
            r_row            <= i_start_y;
            r_byte_in_row    <= '0;
            r_frame_finished <= (i_start_y > i_end_y);
            r_row_drawn      <= (i_end_x < i_start_x);
        end else begin
            if (i_cmd.load) begin
                r_bit <= start_bit;
            end
            if (i_cmd.step) begin
                r_bit <= next_bit[BIT_POS_BITS-1:0];
                if (col_end) begin
                    r_row_drawn <= 1'b1;
                end else begin
                    r_column <= r_column + COORD_BITS'(1);
                end
            end
            if (finish_byte) begin
                if (!row_done) begin
                    r_byte_in_row <= bir_inc;
                end else if (r_row == i_end_y) begin
                    r_byte_in_row    <= bir_inc;
                    r_frame_finished <= 1'b1;
                end else begin
                    r_row         <= r_row + COORD_BITS'(1);
                    r_column      <= i_start_x;
                    r_byte_in_row <= '0;
                    r_row_drawn   <= (i_end_x < i_start_x);
                end
            end
        end
    end

    // Latched input word.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_byte <= i_data_byte;
        end
    end

    // Output register valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.step && cur_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.step && cur_emit) begin
            r_pixel_x     <= r_column;
            r_pixel_y     <= r_row;
            r_pixel_color <= COLOR_BITS'(pal_entry);
            r_last        <= last_pixel;
        end
    end

    assign o_stat.frame_finished = r_frame_finished;
    assign o_stat.row_drawn      = r_row_drawn;
    assign o_stat.emit           = cur_emit;
    assign o_stat.slot_free      = slot_free;
    assign o_stat.last_step      = last_step;

    assign o_out_valid    = r_out_valid;
    assign o_pixel_x      = r_pixel_x;
    assign o_pixel_y      = r_pixel_y;
    assign o_pixel_color  = r_pixel_color;
    assign o_last_of_byte = r_last;

endmodule
